// File: design/hbm_pkg.sv
`timescale 1ns / 1ps

package hbm_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned RateW    = 16;
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 24;

  localparam logic [63:0] OfflineRst = 64'd723401728380240414;
  localparam logic [63:0] SettleRst  = 64'd723401728380306216;
  localparam logic [7:0]  EnableRst  = 8'd247;
  localparam logic [15:0] TickRst    = 16'd1000;
  localparam logic [7:0]  BlinkRst   = 8'd30;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_ARRIVE = 2'd1,
    OP_SCAN   = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    CFG_OFFLINE = 3'd0,
    CFG_SETTLE  = 3'd1,
    CFG_ENABLE  = 3'd2,
    CFG_TICK    = 3'd3,
    CFG_BLINK   = 3'd4
  } cfg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_FINISH,
    ST_EMIT
  } st_e;

  typedef struct packed {
    logic in_ready;
    logic out_valid;
    logic div_start;
    logic upd_lost;
    logic rate_wr;
    logic idx_adv;
    logic idx_clr;
    logic finish;
  } ctl_t;

endpackage

// File: design/multi_device_heartbeat_monitor.sv
`timescale 1ns / 1ps
// Heartbeat monitor for up to DEVICES devices.
// Input stream (s_axis_*): one beat per event. A tick advances the time counter,
// an arrival stamps a device, a scan checks every enabled device.
// Output stream (m_axis_*): a scan yields DEVICES beats, device 0 first, tlast on
// the final one. Ticks and arrivals yield nothing.
// Config channel (cfg_*): always ready; write only while the block is idle.
// Ticks and arrivals are taken in the idle state. A scan holds s_axis_tready low
// until its last result beat is taken. Each enabled device in the normal window
// whose newest arrival is later than the one before it gets a check state plus a
// pass through the shared bit-serial divider (16 steps, then the quotient is
// returned); other devices take the check state only. A finish state then settles
// the error and LED state, after which the DEVICES result beats follow, one per
// cycle with m_axis_tready high.
// A stalled receiver holds the current beat unchanged and pauses the scan.
// Reset marks every device lost, clears times, rates and LED state and loads the
// default configuration.
module multi_device_heartbeat_monitor #(
  parameter int unsigned DEVICES   = 8,
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [1:0] opcode, [4:2] device, [7:5] zero
  input  logic [hbm_pkg::InDataW-1:0]    s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [2:0] device_index, [3] is_lost, [4] status_led_on, [20:5] rate_hz,
  // [21] any_error, [22] red_led, [23] buzzer_active
  output logic [hbm_pkg::OutDataW-1:0]   m_axis_tdata,
  output logic                           m_axis_tlast,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [hbm_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [hbm_pkg::CfgDataW-1:0]   cfg_data_i
);
  import hbm_pkg::*;

  localparam int unsigned IdxW = (DEVICES > 1) ? $clog2(DEVICES) : 1;

  logic [63:0] offline_q;
  logic [63:0] settle_q;
  logic [7:0]  enable_q;
  logic [15:0] tick_q;
  logic [7:0]  blink_q;

  logic [TIME_BITS-1:0] now_q;
  logic [TIME_BITS-1:0] newest_q [DEVICES];
  logic [TIME_BITS-1:0] prev_q   [DEVICES];
  logic [TIME_BITS-1:0] work_q   [DEVICES];
  logic [RateW-1:0]     rate_q   [DEVICES];
  logic [DEVICES-1:0]   lost_q;
  logic [7:0]           scan_cnt_q;
  logic                 red_q;
  logic                 err_q;
  logic [IdxW-1:0]      idx_q;

  ctl_t            ctl;
  op_e             op;
  logic [2:0]      dev_field;
  logic            dev_ok;
  logic [IdxW-1:0] dev_idx;
  logic            in_fire;
  logic [2:0]      sel;
  logic            dev_en;
  logic            last;
  logic [TIME_BITS-1:0] since_work;
  logic [TIME_BITS-1:0] since_new;
  logic [TIME_BITS-1:0] span;
  logic [7:0]      settle_b;
  logic [7:0]      timeout_b;
  logic            in_settle;
  logic            offline;
  logic            need_div;
  logic            div_done;
  logic [RateW-1:0] quotient;
  logic            err_now;
  logic [7:0]      scan_inc;

  assign op        = op_e'(s_axis_tdata[1:0]);
  assign dev_field = s_axis_tdata[4:2];
  assign dev_ok    = 32'(dev_field) < DEVICES;
  assign dev_idx   = dev_field[IdxW-1:0];
  assign in_fire   = s_axis_tvalid && ctl.in_ready;

  assign sel       = 3'(idx_q);
  assign dev_en    = enable_q[sel];
  assign last      = idx_q == IdxW'(DEVICES - 1);
  assign settle_b  = settle_q[8*sel +: 8];
  assign timeout_b = offline_q[8*sel +: 8];

  always_comb begin
    since_work = now_q - work_q[idx_q];
    since_new  = now_q - newest_q[idx_q];
    span       = newest_q[idx_q] - prev_q[idx_q];
    in_settle  = since_work < TIME_BITS'(settle_b);
    offline    = since_new > TIME_BITS'(timeout_b);
    need_div   = dev_en && !in_settle && !offline && (newest_q[idx_q] > prev_q[idx_q]);
    err_now    = |(lost_q & enable_q[DEVICES-1:0]);
    scan_inc   = scan_cnt_q + 8'd1;
  end

  hbm_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_fire_i   (in_fire),
    .op_i        (op),
    .need_div_i  (need_div),
    .dev_en_i    (dev_en),
    .last_i      (last),
    .div_done_i  (div_done),
    .out_ready_i (m_axis_tready),
    .ctl_o       (ctl)
  );

  hbm_div #(
    .TIME_BITS (TIME_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctl.div_start),
    .dividend_i (tick_q),
    .divisor_i  (span),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offline_q <= OfflineRst;
      settle_q  <= SettleRst;
      enable_q  <= EnableRst;
      tick_q    <= TickRst;
      blink_q   <= BlinkRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_OFFLINE: offline_q <= cfg_data_i;
        CFG_SETTLE:  settle_q  <= cfg_data_i;
        CFG_ENABLE:  enable_q  <= cfg_data_i[7:0];
        CFG_TICK:    tick_q    <= cfg_data_i[15:0];
        CFG_BLINK:   blink_q   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q      <= '0;
      lost_q     <= '1;
      scan_cnt_q <= '0;
      red_q      <= 1'b0;
      err_q      <= 1'b0;
      idx_q      <= '0;
      for (int i = 0; i < DEVICES; i++) begin
        newest_q[i] <= '0;
        prev_q[i]   <= '0;
        work_q[i]   <= '0;
        rate_q[i]   <= '0;
      end
    end else begin
      if (in_fire && op == OP_TICK) begin
        now_q <= now_q + TIME_BITS'(1);
      end
      if (in_fire && op == OP_ARRIVE && dev_ok) begin
        prev_q[dev_idx]   <= newest_q[dev_idx];
        newest_q[dev_idx] <= now_q;
        if (lost_q[dev_idx]) begin
          lost_q[dev_idx] <= 1'b0;
          work_q[dev_idx] <= now_q;
        end
      end
      if (ctl.upd_lost) begin
        lost_q[idx_q] <= offline && !in_settle;
      end
      if (ctl.rate_wr) begin
        rate_q[idx_q] <= quotient;
      end
      if (ctl.finish) begin
        err_q <= err_now;
        if (scan_inc == blink_q) begin
          scan_cnt_q <= '0;
          red_q      <= err_now && !red_q;
        end else begin
          scan_cnt_q <= scan_inc;
        end
      end
      if (ctl.idx_clr) begin
        idx_q <= '0;
      end else if (ctl.idx_adv) begin
        idx_q <= idx_q + IdxW'(1);
      end
    end
  end

  assign s_axis_tready = ctl.in_ready;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = ctl.out_valid;
  assign m_axis_tlast  = last;
  assign m_axis_tdata  = {err_q, red_q, err_q, rate_q[idx_q],
                          !(lost_q[idx_q] && dev_en), lost_q[idx_q], sel};

endmodule

// File: design/hbm_div.sv
`timescale 1ns / 1ps

module hbm_div #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [hbm_pkg::RateW-1:0]   dividend_i,
  input  logic [TIME_BITS-1:0]        divisor_i,
  output logic                        done_o,
  output logic [hbm_pkg::RateW-1:0]   quotient_o
);
  import hbm_pkg::*;

  localparam int unsigned CntW = $clog2(RateW + 1);

  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [TIME_BITS-1:0] rem_q, rem_d;
  logic [TIME_BITS-1:0] dvs_q, dvs_d;
  logic [RateW-1:0]     quo_q, quo_d;
  logic [TIME_BITS:0]   trial;
  logic [TIME_BITS:0]   diff;
  logic                 fits;

  always_comb begin
    trial = {rem_q, quo_q[RateW-1]};
    diff  = trial - {1'b0, dvs_q};
    fits  = trial >= {1'b0, dvs_q};
  end

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    done_d = 1'b0;
    if (start_i) begin
      cnt_d  = CntW'(RateW);
      busy_d = 1'b1;
      rem_d  = '0;
      dvs_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = fits ? diff[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
      quo_d = {quo_q[RateW-2:0], fits};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// File: design/hbm_seq.sv
`timescale 1ns / 1ps

module hbm_seq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_fire_i,
  input  hbm_pkg::op_e  op_i,
  input  logic          need_div_i,
  input  logic          dev_en_i,
  input  logic          last_i,
  input  logic          div_done_i,
  input  logic          out_ready_i,
  output hbm_pkg::ctl_t ctl_o
);
  import hbm_pkg::*;

  st_e st_q, st_d;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: begin
        if (in_fire_i && op_i == OP_SCAN) st_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (need_div_i) st_d = ST_DIV;
        else if (last_i) st_d = ST_FINISH;
      end
      ST_DIV: begin
        if (div_done_i) st_d = last_i ? ST_FINISH : ST_CHECK;
      end
      ST_FINISH: st_d = ST_EMIT;
      ST_EMIT: begin
        if (out_ready_i && last_i) st_d = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl_o = '0;
    unique case (st_q)
      ST_IDLE: begin
        ctl_o.in_ready = 1'b1;
        ctl_o.idx_clr  = 1'b1;
      end
      ST_CHECK: begin
        ctl_o.div_start = need_div_i;
        ctl_o.upd_lost  = dev_en_i;
        ctl_o.idx_adv   = !need_div_i && !last_i;
      end
      ST_DIV: begin
        ctl_o.rate_wr = div_done_i;
        ctl_o.idx_adv = div_done_i && !last_i;
      end
      ST_FINISH: begin
        ctl_o.finish  = 1'b1;
        ctl_o.idx_clr = 1'b1;
      end
      ST_EMIT: begin
        ctl_o.out_valid = 1'b1;
        ctl_o.idx_adv   = out_ready_i && !last_i;
      end
      default: ctl_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps

module tb;
  import hbm_pkg::*;

  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned GapCycles  = 10;
  localparam int unsigned TailCycles = 200;

  typedef struct {
    op_e        op;
    logic [2:0] dev;
  } hb_event_t;

  typedef struct {
    logic [2:0]  dev;
    logic        is_lost;
    logic        led_on;
    logic [15:0] rate;
    logic        any_err;
    logic        red;
    logic        buzz;
    logic        last;
  } hb_status_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  multi_device_heartbeat_monitor dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predicted block state and register copies
  logic [63:0] offline_b  = OfflineRst;
  logic [63:0] settle_b   = SettleRst;
  logic [7:0]  watch_mask = EnableRst;
  logic [15:0] tick_hz    = TickRst;
  logic [7:0]  blink_len  = BlinkRst;

  logic [31:0] now_t = '0;
  logic [31:0] new_arr  [8] = '{default: '0};
  logic [31:0] prev_arr [8] = '{default: '0};
  logic [31:0] work_at  [8] = '{default: '0};
  logic [15:0] rate_st  [8] = '{default: '0};
  logic [7:0]  lost = '1;
  logic [7:0]  blink_cnt = '0;
  logic        red = 1'b0;

  hb_event_t  event_q [$];
  hb_status_t status_q [$];

  int unsigned in_beats = 0;
  int unsigned out_beats = 0;
  int unsigned scans_seen = 0;
  int unsigned cfg_writes = 0;
  int unsigned mismatches = 0;
  int unsigned quiet = 0;

  logic        in_taken = 1'b0;
  logic        bursty = 1'b0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  logic [15:0] stall_pat = '1;

  task automatic heartbeat_step(input op_e op, input logic [2:0] dev);
    logic        err;
    logic [31:0] since_work;
    logic [31:0] since_new;
    logic [31:0] span;
    hb_status_t  st;
    case (op)
      OP_TICK: now_t = now_t + 32'd1;
      OP_ARRIVE: begin
        prev_arr[dev] = new_arr[dev];
        new_arr[dev] = now_t;
        if (lost[dev]) begin
          lost[dev] = 1'b0;
          work_at[dev] = now_t;
        end
      end
      OP_SCAN: begin
        scans_seen++;
        for (int i = 0; i < 8; i++) begin
          if (watch_mask[i]) begin
            since_work = now_t - work_at[i];
            since_new = now_t - new_arr[i];
            if (since_work < {24'd0, settle_b[8*i +: 8]}) begin
              lost[i] = 1'b0;
            end else if (since_new > {24'd0, offline_b[8*i +: 8]}) begin
              lost[i] = 1'b1;
            end else begin
              lost[i] = 1'b0;
              if (new_arr[i] > prev_arr[i]) begin
                span = new_arr[i] - prev_arr[i];
                rate_st[i] = 16'({16'd0, tick_hz} / span);
              end
            end
          end
        end
        err = |(lost & watch_mask);
        blink_cnt = blink_cnt + 8'd1;
        if (blink_cnt == blink_len) begin
          red = err ? ~red : 1'b0;
          blink_cnt = '0;
        end
        for (int i = 0; i < 8; i++) begin
          st.dev = 3'(i);
          st.is_lost = lost[i];
          st.led_on = !(lost[i] && watch_mask[i]);
          st.rate = rate_st[i];
          st.any_err = err;
          st.red = red;
          st.buzz = err;
          st.last = (i == 7);
          status_q.push_back(st);
        end
      end
      default: ;
    endcase
  endtask

  task automatic cmp(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("tb: %s expected %0d got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // sample at the rising edge: results, accepted beats, register writes
  always @(posedge clk_i) begin : mon
    hb_status_t want;
    logic       fired;
    fired = 1'b0;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        fired = 1'b1;
        out_beats++;
        if (status_q.size() == 0) begin
          $error("tb: unexpected result beat, tdata %h", m_axis_tdata);
          mismatches++;
        end else begin
          want = status_q.pop_front();
          cmp("device_index", want.dev, m_axis_tdata[2:0]);
          cmp("is_lost", want.is_lost, m_axis_tdata[3]);
          cmp("status_led_on", want.led_on, m_axis_tdata[4]);
          cmp("rate_hz", want.rate, m_axis_tdata[20:5]);
          cmp("any_error", want.any_err, m_axis_tdata[21]);
          cmp("red_led", want.red, m_axis_tdata[22]);
          cmp("buzzer_active", want.buzz, m_axis_tdata[23]);
          cmp("last_of_scan", want.last, m_axis_tlast);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        fired = 1'b1;
        in_beats++;
        in_taken = 1'b1;
        heartbeat_step(op_e'(s_axis_tdata[1:0]), s_axis_tdata[4:2]);
      end
      if (cfg_valid_i && cfg_ready_o) begin
        fired = 1'b1;
        cfg_writes++;
        case (cfg_e'(cfg_index_i))
          CFG_OFFLINE: offline_b = cfg_data_i;
          CFG_SETTLE:  settle_b = cfg_data_i;
          CFG_ENABLE:  watch_mask = cfg_data_i[7:0];
          CFG_TICK:    tick_hz = cfg_data_i[15:0];
          CFG_BLINK:   blink_len = cfg_data_i[7:0];
          default: ;
        endcase
      end
      quiet = fired ? 0 : quiet + 1;
    end
  end

  always @(negedge clk_i) begin
    if (quiet >= QuietLimit) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // input side: bursts of beats, with random gaps when bursty is set
  always @(negedge clk_i) begin : drv
    hb_event_t ev;
    if (!s_axis_tvalid || in_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (event_q.size() > 0) begin
        ev = event_q.pop_front();
        s_axis_tdata <= {3'b000, ev.dev, ev.op};
        s_axis_tvalid <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 12);
          gap_left = bursty ? $urandom_range(0, 9) : 0;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    in_taken = 1'b0;
  end

  // output side: stall on a rotating pattern
  always @(negedge clk_i) begin
    m_axis_tready <= stall_pat[0];
    stall_pat = {stall_pat[0], stall_pat[15:1]};
  end

  task automatic add(input op_e op, input logic [2:0] dev);
    hb_event_t ev;
    ev.op = op;
    ev.dev = dev;
    event_q.push_back(ev);
  endtask

  task automatic drain(input int unsigned tail);
    do @(posedge clk_i); while (event_q.size() != 0 || s_axis_tvalid || status_q.size() != 0);
    repeat (tail) @(negedge clk_i);
  endtask

  task automatic configure(input logic [63:0] offline, input logic [63:0] settle,
                           input logic [7:0] mask, input logic [15:0] tick,
                           input logic [7:0] blink);
    logic [63:0] vals [5];
    vals = '{offline, settle, {56'd0, mask}, {48'd0, tick}, {56'd0, blink}};
    for (int i = 0; i < 5; i++) begin
      @(negedge clk_i);
      cfg_valid_i <= 1'b1;
      cfg_index_i <= CfgIdxW'(i);
      cfg_data_i <= vals[i];
      do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    end
    @(negedge clk_i) cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [63:0] short_bytes();
    logic [63:0] v;
    for (int i = 0; i < 8; i++) v[8*i +: 8] = 8'($urandom_range(0, 12));
    return v;
  endfunction

  // heartbeat-like traffic: arrivals come mostly from a set of live devices, the rest arrive only now and then
  task automatic queue_traffic(input int unsigned n);
    logic [7:0]  alive;
    int unsigned made;
    int unsigned r;
    hb_event_t   ev;
    alive = 8'($urandom);
    made = 0;
    while (made < n) begin
      r = $urandom_range(0, 99);
      ev.dev = 3'($urandom_range(0, 7));
      if (r < 40) begin
        ev.op = OP_TICK;
      end else if (r < 75) begin
        ev.op = OP_ARRIVE;
        if (r < 68 && alive != 0)
          while (!alive[ev.dev]) ev.dev = 3'($urandom_range(0, 7));
      end else if (r < 95) begin
        ev.op = OP_SCAN;
        if ($urandom_range(0, 4) == 0) alive = 8'($urandom);
      end else begin
        ev.op = OP_NONE;
      end
      event_q.push_back(ev);
      if (ev.op != OP_NONE) made++;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset state, unused opcode, disabled device, reconnect, timeouts
    add(OP_SCAN, 3'd0);
    add(OP_NONE, 3'd7);
    add(OP_ARRIVE, 3'd0);
    add(OP_ARRIVE, 3'd7);
    add(OP_ARRIVE, 3'd3);
    add(OP_TICK, 3'd5);
    add(OP_ARRIVE, 3'd0);
    add(OP_TICK, 3'd2);
    add(OP_TICK, 3'd0);
    add(OP_ARRIVE, 3'd0);
    add(OP_ARRIVE, 3'd7);
    add(OP_ARRIVE, 3'd5);
    add(OP_SCAN, 3'd7);
    add(OP_ARRIVE, 3'd2);
    add(OP_ARRIVE, 3'd4);
    add(OP_ARRIVE, 3'd6);
    add(OP_ARRIVE, 3'd1);
    for (int i = 0; i < 6; i++) add(OP_TICK, 3'd0);
    add(OP_SCAN, 3'd0);
    add(OP_NONE, 3'd0);
    drain(GapCycles);

    for (int p = 0; p < 7; p++) begin
      case (p)
        0: configure('0, '0, 8'hFF, 16'hFFFF, 8'd1);
        1: configure('1, '1, 8'hA5, 16'd1, 8'd255);
        2: configure(short_bytes(), short_bytes(), 8'($urandom), 16'd0, 8'd2);
        6: configure('1, '1, 8'h00, 16'd500, 8'd3);
        default: configure(short_bytes(), short_bytes(), 8'($urandom),
                           16'($urandom_range(1, 65535)), 8'($urandom_range(1, 5)));
      endcase
      bursty = p[0];
      stall_pat = (p % 3 == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
      queue_traffic((p == 6) ? 12 : 16);
      drain(GapCycles);
    end

    // scan run with blink period zero: the scan counter climbs past the period
    configure('0, '0, 8'h0F, 16'd1000, 8'd0);
    bursty = 1'b1;
    stall_pat = 16'hF3B7;
    for (int i = 0; i < 45; i++) add(($urandom_range(0, 9) == 0) ? OP_TICK : OP_SCAN, 3'd0);
    drain(TailCycles);

    $display("tb: %0d input beats, %0d scans, %0d result beats, %0d register writes",
             in_beats, scans_seen, out_beats, cfg_writes);
    $display("tb: %0d mismatches, %0d results left outstanding", mismatches, status_q.size());
    if (mismatches == 0 && status_q.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
